@@ src/tcc_pkg.sv @@
package tcc_pkg;

  localparam int ITERATIONS_DEF = 16;
  localparam int ITER_MAX       = 24;

  // binary angle: 2^32 units per turn, with headroom for the half-turn start
  localparam int ZW = 36;
  // CORDIC x/y datapath
  localparam int XW = 34;
  // heading numerator/denominator before normalization
  localparam int NW = 65;
  // square-root operand and result
  localparam int SQ_W  = 32;
  localparam int RT_W  = 30;
  localparam int REM_W = 34;

  localparam logic signed [ZW-1:0] TURN_HALF    = 36'sd2147483648;
  localparam logic signed [ZW-1:0] TURN_QUARTER = 36'sd1073741824;
  localparam logic signed [ZW-1:0] TURN_FULL    = 36'sd4294967296;
  localparam logic signed [XW-1:0] ROT_START    = 34'sd652032874;

  function automatic logic signed [ZW-1:0] atan_entry(input int idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0:       r = 36'sh020000000;
      1:       r = 36'sh012E4051E;
      2:       r = 36'sh009FB385B;
      3:       r = 36'sh0051111D4;
      4:       r = 36'sh0028B0D43;
      5:       r = 36'sh00145D7E1;
      6:       r = 36'sh000A2F61E;
      7:       r = 36'sh000517C55;
      8:       r = 36'sh00028BE53;
      9:       r = 36'sh000145F2F;
      10:      r = 36'sh0000A2F98;
      11:      r = 36'sh0000517CC;
      12:      r = 36'sh000028BE6;
      13:      r = 36'sh0000145F3;
      14:      r = 36'sh00000A2F9;
      15:      r = 36'sh00000517C;
      16:      r = 36'sh0000028BE;
      17:      r = 36'sh00000145F;
      18:      r = 36'sh000000A2F;
      19:      r = 36'sh000000517;
      20:      r = 36'sh00000028B;
      21:      r = 36'sh000000145;
      22:      r = 36'sh0000000A2;
      23:      r = 36'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ src/tcc_in_if.sv @@
interface tcc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] field_x;
  logic signed [15:0] field_y;
  logic signed [15:0] field_z;

  modport source (output valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
                output ready);
endinterface

@@ src/tcc_out_if.sv @@
interface tcc_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] pitch_angle;
  logic signed [14:0] roll_angle;
  logic        [15:0] heading_angle;

  modport source (output valid, pitch_angle, roll_angle, heading_angle, input ready);
  modport sink (input valid, pitch_angle, roll_angle, heading_angle, output ready);
endinterface

@@ src/tilt_compensated_compass.sv @@
// Tilt-compensated compass. Each request carries one accelerometer and one
// magnetometer triple; the block returns pitch and roll in signed hundredths
// of a degree (within +/-9000) and heading in hundredths of a degree
// (0..35999). The datapath is fully pipelined: while the output is not
// stalled, one request is taken every clock and a result leaves every clock.
// The pipeline holds the 30-stage square root, three CORDIC steps in sequence
// of ITERATIONS stages each (tilt vectoring, sine/cosine rotation, heading
// vectoring) and the multiply and normalize stages. A stall at the output
// freezes the whole pipeline; in_chan.ready is high while the output register
// is empty or out_chan.ready is high, and nothing is dropped.
module tilt_compensated_compass #(
  parameter int ITERATIONS = tcc_pkg::ITERATIONS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tcc_in_if.sink    in_chan,
  tcc_out_if.source out_chan
);
  import tcc_pkg::*;

  localparam int NRM_ST = 6;
  localparam int MW     = 48;
  localparam int PW     = 54;
  localparam int CW     = 22;
  localparam logic signed [PW-1:0] HUND_K     = 54'sd36000;
  localparam logic signed [PW-1:0] ROUND_HALF = 54'sd2147483648;
  localparam logic signed [NW-1:0] BIG_LIM    = 65'sd1073741824;
  localparam logic signed [CW-1:0] CENT_TURN  = 22'sd36000;
  localparam logic signed [CW-1:0] CENT_LIM   = 22'sd9000;

  function automatic logic signed [ZW-1:0] fold_quarter(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] r;
    r = z;
    if (z > TURN_QUARTER) begin
      r = z - TURN_HALF;
    end else if (z < -TURN_QUARTER) begin
      r = z + TURN_HALF;
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] to_cent(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = (p + ROUND_HALF) >>> 32;
    return q[CW-1:0];
  endfunction

  function automatic logic signed [14:0] clamp90(input logic signed [CW-1:0] c);
    logic signed [CW-1:0] r;
    r = c;
    if (c > CENT_LIM) begin
      r = CENT_LIM;
    end else if (c < -CENT_LIM) begin
      r = -CENT_LIM;
    end
    return r[14:0];
  endfunction

  function automatic logic is_big(input logic signed [NW-1:0] v);
    return (v >= BIG_LIM) || (v <= -BIG_LIM);
  endfunction

  logic en;
  logic out_valid_r;

  // one enable for every stage: advance unless the output is held
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // squares
  logic signed [31:0] sqy_c, sqz_c;
  logic               sq_vld_r;
  logic [30:0]        sqy_r, sqz_r;
  logic [95:0]        sq_side_r;

  assign sqy_c = in_chan.accel_y * in_chan.accel_y;
  assign sqz_c = in_chan.accel_z * in_chan.accel_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (en) begin
      sq_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqy_r     <= sqy_c[30:0];
      sqz_r     <= sqz_c[30:0];
      sq_side_r <= {in_chan.accel_x, in_chan.accel_y, in_chan.accel_z,
                    in_chan.field_x, in_chan.field_y, in_chan.field_z};
    end
  end

  // sum of squares
  logic            sum_vld_r;
  logic [SQ_W-1:0] sum_r;
  logic [95:0]     sum_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else if (en) begin
      sum_vld_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r      <= {1'b0, sqy_r} + {1'b0, sqz_r};
      sum_side_r <= sq_side_r;
    end
  end

  logic            rt_vld;
  logic [RT_W-1:0] rt_root;
  logic [95:0]     rt_side;

  tcc_sqrt #(
    .SIDE_W (96)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sum_vld_r),
    .in_sum    (sum_r),
    .in_side   (sum_side_r),
    .out_valid (rt_vld),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // pre-rotation for the tilt vectoring
  logic signed [15:0]   ax2, ay2, az2;
  logic signed [XW-1:0] ry_c, rx_c, rxp_c, ryp_c, py_c;
  logic signed [ZW-1:0] rz_c;

  assign ax2 = rt_side[95:80];
  assign ay2 = rt_side[79:64];
  assign az2 = rt_side[63:48];

  always_comb begin
    ry_c = XW'(ay2) <<< 14;
    rx_c = XW'(az2) <<< 14;
    py_c = XW'(ax2) <<< 14;
    if (rx_c[XW-1]) begin
      rxp_c = -rx_c;
      ryp_c = -ry_c;
      rz_c  = ry_c[XW-1] ? -TURN_HALF : TURN_HALF;
    end else begin
      rxp_c = rx_c;
      ryp_c = ry_c;
      rz_c  = '0;
    end
  end

  logic                 pre_vld_r;
  logic signed [XW-1:0] pre_rx_r, pre_ry_r, pre_px_r, pre_py_r;
  logic signed [ZW-1:0] pre_rz_r;
  logic                 pre_rzero_r, pre_pzero_r;
  logic [47:0]          pre_fld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (en) begin
      pre_vld_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_rx_r    <= rxp_c;
      pre_ry_r    <= ryp_c;
      pre_rz_r    <= rz_c;
      pre_rzero_r <= (ay2 == 16'sd0) && (az2 == 16'sd0);
      pre_px_r    <= XW'({1'b0, rt_root});
      pre_py_r    <= py_c;
      pre_pzero_r <= (ax2 == 16'sd0) && (rt_root == '0);
      pre_fld_r   <= rt_side[47:0];
    end
  end

  logic                 va_vld;
  logic signed [ZW-1:0] va_z, vb_z;
  logic [48:0]          va_side;
  logic                 vb_side;

  tcc_cordic #(
    .ITERATIONS (ITERATIONS),
    .VECTORING  (1'b1),
    .SIDE_W     (49)
  ) u_roll_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pre_vld_r),
    .in_x      (pre_rx_r),
    .in_y      (pre_ry_r),
    .in_z      (pre_rz_r),
    .in_side   ({pre_rzero_r, pre_fld_r}),
    .out_valid (va_vld),
    .out_x     (),
    .out_y     (),
    .out_z     (va_z),
    .out_side  (va_side)
  );

  tcc_cordic #(
    .ITERATIONS (ITERATIONS),
    .VECTORING  (1'b1),
    .SIDE_W     (1)
  ) u_pitch_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pre_vld_r),
    .in_x      (pre_px_r),
    .in_y      (pre_py_r),
    .in_z      ('0),
    .in_side   (pre_pzero_r),
    .out_valid (),
    .out_x     (),
    .out_y     (),
    .out_z     (vb_z),
    .out_side  (vb_side)
  );

  // fold to +/- a quarter turn, negate pitch
  logic                 ang_vld_r;
  logic signed [ZW-1:0] ang_roll_r, ang_pitch_r;
  logic [47:0]          ang_fld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_vld_r <= 1'b0;
    end else if (en) begin
      ang_vld_r <= va_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_roll_r  <= va_side[48] ? '0 : fold_quarter(va_z);
      ang_pitch_r <= vb_side ? '0 : -fold_quarter(vb_z);
      ang_fld_r   <= va_side[47:0];
    end
  end

  logic                 rc_vld;
  logic signed [XW-1:0] rc_cos, rc_sin, rd_cos, rd_sin;
  logic [83:0]          rc_side;
  logic [ZW-1:0]        rd_side;

  tcc_cordic #(
    .ITERATIONS (ITERATIONS),
    .VECTORING  (1'b0),
    .SIDE_W     (84)
  ) u_roll_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ang_vld_r),
    .in_x      (ROT_START),
    .in_y      ('0),
    .in_z      (ang_roll_r),
    .in_side   ({ang_fld_r, ang_roll_r}),
    .out_valid (rc_vld),
    .out_x     (rc_cos),
    .out_y     (rc_sin),
    .out_z     (),
    .out_side  (rc_side)
  );

  tcc_cordic #(
    .ITERATIONS (ITERATIONS),
    .VECTORING  (1'b0),
    .SIDE_W     (ZW)
  ) u_pitch_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ang_vld_r),
    .in_x      (ROT_START),
    .in_y      ('0),
    .in_z      (ang_pitch_r),
    .in_side   (ang_pitch_r),
    .out_valid (),
    .out_x     (rd_cos),
    .out_y     (rd_sin),
    .out_z     (),
    .out_side  (rd_side)
  );

  // products of field and trig terms
  logic signed [15:0]   fx4, fy4, fz4;
  logic signed [31:0]   cr4, sr4, cp4;
  logic signed [ZW-1:0] roll4, pitch4;

  assign fx4    = rc_side[83:68];
  assign fy4    = rc_side[67:52];
  assign fz4    = rc_side[51:36];
  assign roll4  = rc_side[ZW-1:0];
  assign pitch4 = rd_side;
  assign cr4    = rc_cos[31:0];
  assign sr4    = rc_sin[31:0];
  assign cp4    = rd_cos[31:0];

  logic                 mul_vld_r;
  logic signed [MW-1:0] mul_fycr_r, mul_fzsr_r, mul_fysr_r, mul_fzcr_r, mul_fxcp_r;
  logic signed [31:0]   mul_sp_r;
  logic signed [PW-1:0] mul_rollp_r, mul_pitchp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (en) begin
      mul_vld_r <= rc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_fycr_r   <= MW'(fy4) * MW'(cr4);
      mul_fzsr_r   <= MW'(fz4) * MW'(sr4);
      mul_fysr_r   <= MW'(fy4) * MW'(sr4);
      mul_fzcr_r   <= MW'(fz4) * MW'(cr4);
      mul_fxcp_r   <= MW'(fx4) * MW'(cp4);
      mul_sp_r     <= rd_sin[31:0];
      mul_rollp_r  <= PW'(roll4) * HUND_K;
      mul_pitchp_r <= PW'(pitch4) * HUND_K;
    end
  end

  // numerator, roll-combined term, angle rounding
  logic signed [NW-1:0] dn_c, ts_c;
  logic                 trm_vld_r;
  logic signed [NW-1:0] trm_n_r, trm_xc_r;
  logic signed [31:0]   trm_t_r, trm_sp_r;
  logic [29:0]          trm_ang_r;

  assign dn_c = NW'(mul_fycr_r) - NW'(mul_fzsr_r);
  assign ts_c = NW'(mul_fysr_r) + NW'(mul_fzcr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trm_vld_r <= 1'b0;
    end else if (en) begin
      trm_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trm_n_r   <= -(dn_c <<< 15);
      trm_t_r   <= ts_c[46:15];
      trm_xc_r  <= NW'(mul_fxcp_r) <<< 15;
      trm_sp_r  <= mul_sp_r;
      trm_ang_r <= {clamp90(to_cent(mul_pitchp_r)), clamp90(to_cent(mul_rollp_r))};
    end
  end

  logic                 prd_vld_r;
  logic signed [NW-1:0] prd_tsp_r, prd_xc_r, prd_n_r;
  logic [29:0]          prd_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_vld_r <= 1'b0;
    end else if (en) begin
      prd_vld_r <= trm_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prd_tsp_r <= NW'(trm_t_r) * NW'(trm_sp_r);
      prd_xc_r  <= trm_xc_r;
      prd_n_r   <= trm_n_r;
      prd_ang_r <= trm_ang_r;
    end
  end

  logic                 den_vld_r;
  logic signed [NW-1:0] den_d_r, den_n_r;
  logic [29:0]          den_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      den_vld_r <= 1'b0;
    end else if (en) begin
      den_vld_r <= prd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_d_r   <= prd_tsp_r + prd_xc_r;
      den_n_r   <= prd_n_r;
      den_ang_r <= prd_ang_r;
    end
  end

  // halve n and d together until both fit: binary search for the shift
  logic                 nrm_vld_r [NRM_ST];
  logic signed [NW-1:0] nrm_n_r   [NRM_ST];
  logic signed [NW-1:0] nrm_d_r   [NRM_ST];
  logic [29:0]          nrm_ang_r [NRM_ST];

  genvar k;
  generate
    for (k = 0; k < NRM_ST; k++) begin : g_nrm
      localparam int SH = 1 << (NRM_ST - 1 - k);
      logic                 vld_in;
      logic signed [NW-1:0] n_in, d_in;
      logic [29:0]          ang_in;
      logic                 still_big;

      if (k == 0) begin : g_first
        assign vld_in = den_vld_r;
        assign n_in   = den_n_r;
        assign d_in   = den_d_r;
        assign ang_in = den_ang_r;
      end else begin : g_next
        assign vld_in = nrm_vld_r[k-1];
        assign n_in   = nrm_n_r[k-1];
        assign d_in   = nrm_d_r[k-1];
        assign ang_in = nrm_ang_r[k-1];
      end

      assign still_big = is_big(n_in >>> (SH - 1)) || is_big(d_in >>> (SH - 1));

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          nrm_vld_r[k] <= 1'b0;
        end else if (en) begin
          nrm_vld_r[k] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          nrm_n_r[k]   <= still_big ? (n_in >>> SH) : n_in;
          nrm_d_r[k]   <= still_big ? (d_in >>> SH) : d_in;
          nrm_ang_r[k] <= ang_in;
        end
      end
    end
  endgenerate

  // pre-rotation for the heading vectoring
  logic signed [XW-1:0] hy_c, hx_c, hxp_c, hyp_c;
  logic signed [ZW-1:0] hz_c;

  always_comb begin
    hy_c = XW'(nrm_n_r[NRM_ST-1]);
    hx_c = XW'(nrm_d_r[NRM_ST-1]);
    if (hx_c[XW-1]) begin
      hxp_c = -hx_c;
      hyp_c = -hy_c;
      hz_c  = hy_c[XW-1] ? -TURN_HALF : TURN_HALF;
    end else begin
      hxp_c = hx_c;
      hyp_c = hy_c;
      hz_c  = '0;
    end
  end

  logic                 hp_vld_r;
  logic signed [XW-1:0] hp_x_r, hp_y_r;
  logic signed [ZW-1:0] hp_z_r;
  logic [30:0]          hp_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_vld_r <= 1'b0;
    end else if (en) begin
      hp_vld_r <= nrm_vld_r[NRM_ST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hp_x_r    <= hxp_c;
      hp_y_r    <= hyp_c;
      hp_z_r    <= hz_c;
      hp_side_r <= {(hy_c == '0) && (hx_c == '0), nrm_ang_r[NRM_ST-1]};
    end
  end

  logic                 he_vld;
  logic signed [ZW-1:0] he_z;
  logic [30:0]          he_side;

  tcc_cordic #(
    .ITERATIONS (ITERATIONS),
    .VECTORING  (1'b1),
    .SIDE_W     (31)
  ) u_head_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (hp_vld_r),
    .in_x      (hp_x_r),
    .in_y      (hp_y_r),
    .in_z      (hp_z_r),
    .in_side   (hp_side_r),
    .out_valid (he_vld),
    .out_x     (),
    .out_y     (),
    .out_z     (he_z),
    .out_side  (he_side)
  );

  // wrap heading into one turn, scale to hundredths
  logic signed [ZW-1:0] head_c;
  logic                 hd_vld_r;
  logic signed [PW-1:0] hd_prod_r;
  logic [29:0]          hd_ang_r;

  always_comb begin
    head_c = he_side[30] ? '0 : he_z;
    if (head_c[ZW-1]) begin
      head_c = head_c + TURN_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_vld_r <= 1'b0;
    end else if (en) begin
      hd_vld_r <= he_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hd_prod_r <= PW'(head_c) * HUND_K;
      hd_ang_r  <= he_side[29:0];
    end
  end

  // output register
  logic signed [CW-1:0] hh_c;
  logic signed [14:0]   pitch_r, roll_r;
  logic [15:0]          head_r;

  always_comb begin
    hh_c = to_cent(hd_prod_r);
    if (hh_c >= CENT_TURN) begin
      hh_c = hh_c - CENT_TURN;
    end
    if (hh_c[CW-1]) begin
      hh_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= hd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_r <= hd_ang_r[29:15];
      roll_r  <= hd_ang_r[14:0];
      head_r  <= hh_c[15:0];
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.pitch_angle   = pitch_r;
  assign out_chan.roll_angle    = roll_r;
  assign out_chan.heading_angle = head_r;

endmodule

@@ src/tcc_sqrt.sv @@
module tcc_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [tcc_pkg::SQ_W-1:0]   in_sum,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [tcc_pkg::RT_W-1:0]   out_root,
  output logic [SIDE_W-1:0]          out_side
);
  import tcc_pkg::*;

  // floor(sqrt(in_sum * 2^28)), one result bit per stage
  localparam int SUM_ST = SQ_W / 2;

  logic              vld_r  [RT_W];
  logic [RT_W-1:0]   root_r [RT_W];
  logic [REM_W-1:0]  rem_r  [RT_W-1];
  logic [SQ_W-1:0]   sum_r  [SUM_ST-1];
  logic [SIDE_W-1:0] side_r [RT_W];

  genvar j;
  generate
    for (j = 0; j < RT_W; j++) begin : g_stage
      logic              vld_in;
      logic [RT_W-1:0]   root_in;
      logic [REM_W-1:0]  rem_in;
      logic [SIDE_W-1:0] side_in;
      logic [1:0]        pair;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_nxt;
      logic [RT_W-1:0]   root_nxt;

      if (j == 0) begin : g_first
        assign vld_in  = in_valid;
        assign root_in = '0;
        assign rem_in  = '0;
        assign side_in = in_side;
        assign pair    = in_sum[SQ_W-1 -: 2];
      end else begin : g_next
        assign vld_in  = vld_r[j-1];
        assign root_in = root_r[j-1];
        assign rem_in  = rem_r[j-1];
        assign side_in = side_r[j-1];
        if (j < SUM_ST) begin : g_bits
          assign pair = sum_r[j-1][SQ_W-1-2*j -: 2];
        end else begin : g_zero
          assign pair = 2'b00;
        end
      end

      always_comb begin
        rem_sh = {rem_in[REM_W-3:0], pair};
        trial  = REM_W'({root_in, 2'b01});
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_in[RT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_in[RT_W-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[j] <= 1'b0;
        end else if (en) begin
          vld_r[j] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          root_r[j] <= root_nxt;
          side_r[j] <= side_in;
        end
      end

      if (j < RT_W - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[j] <= rem_nxt;
          end
        end
      end

      if (j < SUM_ST - 1) begin : g_sum
        if (j == 0) begin : g_sum_first
          always_ff @(posedge clk) begin
            if (en) begin
              sum_r[j] <= in_sum;
            end
          end
        end else begin : g_sum_next
          always_ff @(posedge clk) begin
            if (en) begin
              sum_r[j] <= sum_r[j-1];
            end
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[RT_W-1];
  assign out_root  = root_r[RT_W-1];
  assign out_side  = side_r[RT_W-1];

endmodule

@@ src/tcc_cordic.sv @@
module tcc_cordic #(
  parameter int ITERATIONS = tcc_pkg::ITERATIONS_DEF,
  parameter bit VECTORING  = 1'b1,
  parameter int SIDE_W     = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [tcc_pkg::XW-1:0] in_x,
  input  logic signed [tcc_pkg::XW-1:0] in_y,
  input  logic signed [tcc_pkg::ZW-1:0] in_z,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic signed [tcc_pkg::XW-1:0] out_x,
  output logic signed [tcc_pkg::XW-1:0] out_y,
  output logic signed [tcc_pkg::ZW-1:0] out_z,
  output logic [SIDE_W-1:0]           out_side
);
  import tcc_pkg::*;

  logic                 vld_r  [ITERATIONS];
  logic signed [XW-1:0] x_r    [ITERATIONS];
  logic signed [XW-1:0] y_r    [ITERATIONS];
  logic signed [ZW-1:0] z_r    [ITERATIONS];
  logic [SIDE_W-1:0]    side_r [ITERATIONS];

  genvar i;
  generate
    for (i = 0; i < ITERATIONS; i++) begin : g_stage
      logic                 vld_in;
      logic signed [XW-1:0] x_in;
      logic signed [XW-1:0] y_in;
      logic signed [ZW-1:0] z_in;
      logic [SIDE_W-1:0]    side_in;
      logic                 cw;
      logic signed [XW-1:0] x_nxt;
      logic signed [XW-1:0] y_nxt;
      logic signed [ZW-1:0] z_nxt;

      if (i == 0) begin : g_first
        assign vld_in  = in_valid;
        assign x_in    = in_x;
        assign y_in    = in_y;
        assign z_in    = in_z;
        assign side_in = in_side;
      end else begin : g_next
        assign vld_in  = vld_r[i-1];
        assign x_in    = x_r[i-1];
        assign y_in    = y_r[i-1];
        assign z_in    = z_r[i-1];
        assign side_in = side_r[i-1];
      end

      always_comb begin
        // vectoring drives y to zero, rotation drives z to zero
        cw = VECTORING ? !y_in[XW-1] : z_in[ZW-1];
        if (cw) begin
          x_nxt = x_in + (y_in >>> i);
          y_nxt = y_in - (x_in >>> i);
          z_nxt = z_in + atan_entry(i);
        end else begin
          x_nxt = x_in - (y_in >>> i);
          y_nxt = y_in + (x_in >>> i);
          z_nxt = z_in - atan_entry(i);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (en) begin
          vld_r[i] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_r[i]    <= x_nxt;
          y_r[i]    <= y_nxt;
          z_r[i]    <= z_nxt;
          side_r[i] <= side_in;
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[ITERATIONS-1];
  assign out_x     = x_r[ITERATIONS-1];
  assign out_y     = y_r[ITERATIONS-1];
  assign out_z     = z_r[ITERATIONS-1];
  assign out_side  = side_r[ITERATIONS-1];

endmodule

@@ dv/tilt_compensated_compass_test.sv @@
`timescale 1ns / 100ps

module tilt_compensated_compass_test;
  import tcc_pkg::*;

  localparam int     NUM_RANDOM   = 530;
  localparam int     IDLE_LIMIT   = 4000;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     DRAIN_CYCLES = 3 * (48 + 3 * ITERATIONS_DEF);
  localparam longint HALF_TURN    = 64'sd2147483648;
  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam longint UNIT_GAIN    = 64'sd652032874;

  localparam longint ARCTAN [24] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
    'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051
  };

  typedef struct {
    logic signed [15:0] ax, ay, az, fx, fy, fz;
  } sample_t;

  typedef struct {
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
    logic [15:0]        heading;
  } attitude_t;

  typedef struct {
    sample_t   smp;
    bit        known;
    attitude_t att;
  } vector_row_t;

  logic clk;
  logic rst_n;

  tcc_in_if  in_chan ();
  tcc_out_if out_chan ();

  tilt_compensated_compass DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  attitude_t   attitude_q[$];
  attitude_t   typed_q[$];
  bit          typed_flag_q[$];
  int          errors;
  int          idle_cycles;
  bit          stim_done;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint vector_angle(input longint y_in, input longint x_in);
    longint x, y, z, dx, dy;
    int     i;
    x = x_in;
    y = y_in;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (i = 0; i < ITERATIONS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ARCTAN[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end
    end
    return z;
  endfunction

  function automatic void rotate_unit(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    int     i;
    x = UNIT_GAIN;
    y = 0;
    z = ang;
    for (i = 0; i < ITERATIONS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic longint fold_tilt(input longint z);
    if (z > QUARTER_TURN) return z - HALF_TURN;
    if (z < -QUARTER_TURN) return z + HALF_TURN;
    return z;
  endfunction

  function automatic longint isqrt(input longint unsigned v_in);
    longint unsigned v, res, b;
    v   = v_in;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v  -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint centideg(input longint z);
    return (z * 36000 + HALF_TURN) >>> 32;
  endfunction

  function automatic longint clamp_tilt(input longint h);
    if (h > 9000) return 9000;
    if (h < -9000) return -9000;
    return h;
  endfunction

  function automatic attitude_t predict_attitude(input sample_t s);
    longint    ax, ay, az, fx, fy, fz;
    longint    roll, pitch, sr, cr, sp, cp, n, d, t, head, hh;
    attitude_t r;
    ax = s.ax; ay = s.ay; az = s.az;
    fx = s.fx; fy = s.fy; fz = s.fz;
    roll  = fold_tilt(vector_angle(ay * 16384, az * 16384));
    pitch = -fold_tilt(vector_angle(ax * 16384,
                                    isqrt(longint'(ay * ay + az * az) << 28)));
    rotate_unit(roll, sr, cr);
    rotate_unit(pitch, sp, cp);
    n = -(fy * cr - fz * sr) * 32768;
    t = (fy * sr + fz * cr) >>> 15;
    d = t * sp + fx * cp * 32768;
    // normalize both terms together to keep the ratio
    while ((n < 0 ? -n : n) >= QUARTER_TURN || (d < 0 ? -d : d) >= QUARTER_TURN) begin
      n = n >>> 1;
      d = d >>> 1;
    end
    head = vector_angle(n, d);
    if (head < 0) head += 2 * HALF_TURN;
    hh = centideg(head);
    if (hh >= 36000) hh -= 36000;
    if (hh < 0) hh = 0;
    r.pitch   = 15'(clamp_tilt(centideg(pitch)));
    r.roll    = 15'(clamp_tilt(centideg(roll)));
    r.heading = 16'(hh);
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [15:0] pick_axis(input int kind);
    logic [15:0] e [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
    case (kind)
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($signed($urandom_range(0, 4000)) - 2000);
      2:       return e[$urandom_range(0, 4)];
      default: return 16'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      k;
    k    = $urandom_range(0, 9);
    s.ax = pick_axis(k < 4 ? 0 : k < 6 ? 1 : k == 8 ? 2 : 3);
    s.ay = pick_axis(k < 4 ? 0 : k < 6 ? 1 : k == 8 ? 2 : 3);
    s.az = pick_axis(k < 4 ? 0 : k < 6 ? 1 : k == 8 ? 2 : 3);
    s.fx = pick_axis(k < 4 ? 0 : k == 8 ? 2 : 3);
    s.fy = pick_axis(k < 4 ? 0 : k == 8 ? 2 : 3);
    s.fz = pick_axis(k < 4 ? 0 : k == 8 ? 2 : 3);
    // flat or vertical attitudes with zero axes
    if (k == 9) begin
      s.ay = '0;
      s.az = '0;
    end
    if (k == 7) s.ax = '0;
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    in_chan.valid   <= 1'b1;
    in_chan.accel_x <= s.ax;
    in_chan.accel_y <= s.ay;
    in_chan.accel_z <= s.az;
    in_chan.field_x <= s.fx;
    in_chan.field_y <= s.fy;
    in_chan.field_z <= s.fz;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  int burst_left;

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  vector_row_t vectors[$];

  initial begin
    vector_row_t v;
    sample_t     s;
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.accel_x  = '0;
    in_chan.accel_y  = '0;
    in_chan.accel_z  = '0;
    in_chan.field_x  = '0;
    in_chan.field_y  = '0;
    in_chan.field_z  = '0;
    out_chan.ready   = 1'b0;
    errors           = 0;
    stim_done        = 1'b0;
    hold_req         = 1'b0;
    burst_left       = 0;

    // all-zero sample: every atan2 sees the zero vector
    vectors.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0}});
    vectors.push_back('{'{0, 0, 0, 100, 0, 0}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{32767, 32767, 32767, 32767, 32767, 32767}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{-32768, -32768, -32768, -32768, -32768, -32768}, 1'b0,
                       '{0, 0, 0}});
    vectors.push_back('{'{32767, 0, 0, 1000, 2000, 3000}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{-32768, 0, 0, -1000, 2000, -3000}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{0, 0, 16384, 16384, 0, 0}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{0, 0, 16384, -16384, 0, 0}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{0, 0, 16384, 0, 16384, 0}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{0, 0, 16384, 0, -16384, 0}, 1'b0, '{0, 0, 0}});
    // roll past a quarter turn needs folding both ways
    vectors.push_back('{'{0, 1000, -16384, 5000, 100, -300}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{0, -1000, -16384, 5000, 100, -300}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{0, 32767, 0, 100, 200, 300}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{0, -32768, 0, 100, 200, 300}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{-1, -1, -1, -1, -1, -1}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{1, 1, 1, 1, 1, 1}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{8000, -6000, 14000, -20000, 9000, 300}, 1'b0, '{0, 0, 0}});
    vectors.push_back('{'{0, 0, 0, 32767, -32768, 32767}, 1'b0, '{0, 0, 0}});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      typed_flag_q.push_back(vectors[i].known);
      typed_q.push_back(vectors[i].att);
      send_sample(vectors[i].smp);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 150) hold_req = 1'b1;
      pace_sender();
      s = random_sample();
      typed_flag_q.push_back(1'b0);
      typed_q.push_back('{0, 0, 0});
      send_sample(s);
    end
    in_chan.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: cycles through randomly drawn stall modes; one long hold on request
  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      for (span = 0; span < 64; span++) begin
        @(posedge clk);
        if (hold_req && !held) begin
          held = 1'b1;
          out_chan.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       out_chan.ready <= 1'b1;
          1:       out_chan.ready <= ($urandom_range(0, 3) != 0);
          2:       out_chan.ready <= ($urandom_range(0, 1) != 0);
          default: out_chan.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    sample_t   s;
    attitude_t want;
    attitude_t got;
    attitude_t typed;
    bit        is_typed;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        s.ax = in_chan.accel_x;
        s.ay = in_chan.accel_y;
        s.az = in_chan.accel_z;
        s.fx = in_chan.field_x;
        s.fy = in_chan.field_y;
        s.fz = in_chan.field_z;
        want     = predict_attitude(s);
        is_typed = typed_flag_q.pop_front();
        typed    = typed_q.pop_front();
        attitude_q.push_back(is_typed ? typed : want);
      end
      if (out_chan.valid && out_chan.ready) begin
        got.pitch   = out_chan.pitch_angle;
        got.roll    = out_chan.roll_angle;
        got.heading = out_chan.heading_angle;
        if (attitude_q.size() == 0) begin
          $display("[%0t] unexpected result pitch %0d roll %0d heading %0d",
                   $realtime, got.pitch, got.roll, got.heading);
          errors++;
        end else begin
          want = attitude_q.pop_front();
          if (got.pitch !== want.pitch) report("pitch_angle", got.pitch, want.pitch);
          if (got.roll !== want.roll) report("roll_angle", got.roll, want.roll);
          if (got.heading !== want.heading)
            report("heading_angle", got.heading, want.heading);
        end
      end
    end
  end

  // watchdog: stop when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (attitude_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && attitude_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ tilt_compensated_compass.f @@
src/tcc_pkg.sv
src/tcc_in_if.sv
src/tcc_out_if.sv
src/tcc_sqrt.sv
src/tcc_cordic.sv
src/tilt_compensated_compass.sv
dv/tilt_compensated_compass_test.sv
